/* sv/ibpu_pkg.sv */
// Shared constants, codes and types of the icon bitmap pixel unpacker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ibpu_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int MAX_DIMENSION_DEF = 256;
  localparam int PALETTE_DEPTH_DEF = 256;

  // Field widths
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 8;
  localparam int PAYLOAD_W  = 24;
  localparam int COLOR_W    = 24;
  localparam int POS_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int FMT_W      = 3;
  localparam int DIM_W      = 9;

  // Item actions
  localparam logic [ACTION_W-1:0] ACT_PALETTE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MASK    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DATA    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Pixel formats; unlisted codes decode as 8 bpp
  localparam logic [FMT_W-1:0] FMT_1BPP  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_2BPP  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_4BPP  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_8BPP  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_24BPP = 3'd4;

  localparam logic [FMT_W-1:0] FMT_RESET = FMT_8BPP;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd32;

  localparam logic [COLOR_W-1:0] TRANSPARENT_COLOR = 24'hC6C6C6;

  typedef struct packed {
    logic [FMT_W-1:0] fmt;
    logic [DIM_W-1:0] width;   // already clamped to 1..MAX_DIMENSION
    logic [DIM_W-1:0] height;  // already clamped to 1..MAX_DIMENSION
  } cfg_t;

  // One decoded pixel, handed from the unpack stage to the output register
  typedef struct packed {
    logic [COLOR_W-1:0] color;     // used when use_pal is low
    logic               use_pal;   // take the color from the palette read data
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic               run_last;
    logic               image_last;
    logic               mask_underrun;
  } pix_t;

endpackage

`default_nettype wire

/* sv/ibpu_if.sv */
// Valid/ready channel interfaces of the icon bitmap pixel unpacker.
// Depends on ibpu_pkg for the field widths.
`default_nettype none

interface ibpu_in_if;
  import ibpu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [INDEX_W-1:0]   palette_index;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, output action, output palette_index, output payload,
                  input ready);
  modport sink   (input valid, input action, input palette_index, input payload,
                  output ready);
endinterface

interface ibpu_out_if;
  import ibpu_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [POS_W-1:0]   column;
  logic [POS_W-1:0]   row;
  logic               run_last;
  logic               image_last;
  logic               mask_underrun;

  modport source (output valid, output pixel_color, output column, output row,
                  output run_last, output image_last, output mask_underrun,
                  input ready);
  modport sink   (input valid, input pixel_color, input column, input row,
                  input run_last, input image_last, input mask_underrun,
                  output ready);
endinterface

`default_nettype wire

/* sv/ibpu_cfg.sv */
// Configuration registers: pixel format and clamped image dimensions.
// Depends on ibpu_pkg.
`default_nettype none

module ibpu_cfg #(
  parameter int MAX_DIMENSION = ibpu_pkg::MAX_DIMENSION_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ibpu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ibpu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ibpu_pkg::cfg_t                   cfg_o
);
  import ibpu_pkg::*;

  localparam logic [DIM_W-1:0] DimMax = DIM_W'(MAX_DIMENSION);
  localparam logic [DIM_W-1:0] DimRst = (DIM_RESET > DimMax) ? DimMax : DIM_RESET;

  // zero reads as one, anything past the maximum saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DimMax) r = DimMax;
    return r;
  endfunction

  logic [FMT_W-1:0] fmt_q;
  logic [DIM_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_RESET;
      width_q  <= DimRst;
      height_q <= DimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FORMAT: fmt_q    <= cfg_data_i[FMT_W-1:0];
        CFG_WIDTH:  width_q  <= clamp_dim(cfg_data_i);
        CFG_HEIGHT: height_q <= clamp_dim(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign cfg_o.fmt    = fmt_q;
  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;

endmodule

`default_nettype wire

/* sv/ibpu_palette.sv */
// Palette memory: one write port, one read port with registered read data.
// Depends on ibpu_pkg for the color width.
`default_nettype none

module ibpu_palette #(
  parameter  int PALETTE_DEPTH = ibpu_pkg::PALETTE_DEPTH_DEF,
  localparam int PalAw         = $clog2(PALETTE_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [PalAw-1:0]              waddr_i,
  input  logic [ibpu_pkg::COLOR_W-1:0]  wdata_i,
  input  logic                          re_i,
  input  logic [PalAw-1:0]              raddr_i,
  output logic [ibpu_pkg::COLOR_W-1:0]  rdata_o
);
  import ibpu_pkg::*;

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued, so a stalled pixel keeps its color
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/ibpu_unpack.sv */
// Unpack stage: input item register, pixel field extraction, mask bits and
// row/column counters; issues palette writes and reads. Depends on ibpu_pkg, ibpu_if.
`default_nettype none

module ibpu_unpack #(
  parameter  int PALETTE_DEPTH = ibpu_pkg::PALETTE_DEPTH_DEF,
  localparam int PalAw         = $clog2(PALETTE_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ibpu_pkg::cfg_t                cfg_i,
  ibpu_in_if.sink                       in_i,
  input  logic                          pix_ready_i,
  output logic                          pix_valid_o,
  output ibpu_pkg::pix_t                pix_o,
  output logic                          pal_we_o,
  output logic [PalAw-1:0]              pal_waddr_o,
  output logic [ibpu_pkg::COLOR_W-1:0]  pal_wdata_o,
  output logic                          pal_re_o,
  output logic [PalAw-1:0]              pal_raddr_o
);
  import ibpu_pkg::*;

  localparam logic [DIM_W-1:0] PalDepth = DIM_W'(PALETTE_DEPTH);

  // held item
  logic                 a_valid_q, a_valid_d;
  logic [ACTION_W-1:0]  a_action_q;
  logic [INDEX_W-1:0]   a_index_q;
  logic [PAYLOAD_W-1:0] a_pay_q;
  logic [2:0]           k_q;

  // image state
  logic [POS_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [7:0]       mask_bits_q, mask_bits_d;
  logic [3:0]       mask_pos_q, mask_pos_d;
  logic             image_done_q, image_done_d;

  logic             is_data, live, emit, done, in_fire;
  logic             direct, clear, under, end_row, last, in_range;
  logic [2:0]       count_m1;
  logic [7:0]       e, sh;
  logic [DIM_W-1:0] col_next, row_next, row_dist;

  assign is_data = a_valid_q && (a_action_q == ACT_DATA);
  assign live    = is_data && !image_done_q && (row_q < cfg_i.height);
  assign emit    = live && pix_ready_i;

  // field of the current pixel sits at the top of the shifted data byte
  always_comb begin
    direct   = 1'b0;
    count_m1 = 3'd0;
    e        = a_pay_q[7:0];
    sh       = a_pay_q[7:0];
    unique case (cfg_i.fmt)
      FMT_1BPP: begin
        count_m1 = 3'd7;
        e        = {7'd0, a_pay_q[7]};
        sh       = {a_pay_q[6:0], 1'b0};
      end
      FMT_2BPP: begin
        count_m1 = 3'd3;
        e        = {6'd0, a_pay_q[7:6]};
        sh       = {a_pay_q[5:0], 2'b0};
      end
      FMT_4BPP: begin
        count_m1 = 3'd1;
        e        = {4'd0, a_pay_q[7:4]};
        sh       = {a_pay_q[3:0], 4'b0};
      end
      FMT_24BPP: begin
        direct = 1'b1;
      end
      default: ;
    endcase
  end

  assign col_next = {1'b0, col_q} + DIM_W'(1);
  assign row_next = row_q + DIM_W'(1);
  assign row_dist = cfg_i.height - row_q - DIM_W'(1);
  assign end_row  = col_next >= cfg_i.width;
  assign last     = end_row || (k_q == count_m1);
  assign clear    = (mask_pos_q != 4'd0) && mask_bits_q[7];
  assign under    = (mask_pos_q == 4'd0);
  assign in_range = {1'b0, e} < PalDepth;

  assign pix_o.color         = clear  ? TRANSPARENT_COLOR :
                               direct ? a_pay_q : '0;
  assign pix_o.use_pal       = !clear && !direct && in_range;
  assign pix_o.column        = col_q;
  assign pix_o.row           = row_dist[POS_W-1:0];
  assign pix_o.run_last      = last;
  assign pix_o.image_last    = end_row && (row_next >= cfg_i.height);
  assign pix_o.mask_underrun = under;
  assign pix_valid_o         = emit;

  // non-data items and dropped data items leave without waiting on the pixel ready
  assign done      = a_valid_q && (!is_data || !live || (emit && last));
  assign in_i.ready = !a_valid_q || done;
  assign in_fire   = in_i.valid && in_i.ready;
  assign a_valid_d = in_fire ? 1'b1 : (done ? 1'b0 : a_valid_q);

  assign pal_we_o    = a_valid_q && (a_action_q == ACT_PALETTE) &&
                       ({1'b0, a_index_q} < PalDepth);
  assign pal_waddr_o = a_index_q[PalAw-1:0];
  assign pal_wdata_o = a_pay_q;
  assign pal_re_o    = emit && pix_o.use_pal;
  assign pal_raddr_o = e[PalAw-1:0];

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    mask_bits_d  = mask_bits_q;
    mask_pos_d   = mask_pos_q;
    image_done_d = image_done_q;
    if (emit) begin
      if (end_row) begin
        col_d        = '0;
        row_d        = row_next;
        mask_bits_d  = '0;
        mask_pos_d   = '0;
        image_done_d = row_next >= cfg_i.height;
      end else begin
        col_d = col_next[POS_W-1:0];
        if (!under) begin
          mask_bits_d = {mask_bits_q[6:0], 1'b0};
          mask_pos_d  = mask_pos_q - 4'd1;
        end
      end
    end else if (is_data && !image_done_q && !(row_q < cfg_i.height)) begin
      // height already reached: this item closes the image silently
      image_done_d = 1'b1;
    end else if (a_valid_q && (a_action_q == ACT_MASK)) begin
      mask_bits_d = a_pay_q[7:0];
      mask_pos_d  = 4'd8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
      mask_bits_q  <= '0;
      mask_pos_q   <= '0;
      image_done_q <= 1'b0;
    end else begin
      a_valid_q    <= a_valid_d;
      col_q        <= col_d;
      row_q        <= row_d;
      mask_bits_q  <= mask_bits_d;
      mask_pos_q   <= mask_pos_d;
      image_done_q <= image_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_action_q <= in_i.action;
      a_index_q  <= in_i.palette_index;
      a_pay_q    <= in_i.payload;
      k_q        <= '0;
    end else if (emit) begin
      a_pay_q[7:0] <= sh;
      k_q          <= k_q + 3'd1;
    end
  end

`ifndef NO_ASSERTIONS
  a_mask_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_pos_q <= 4'd8)
    else $error("mask bit count above eight");

  a_row_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && end_row |=> (mask_pos_q == 4'd0) && (col_q == '0))
    else $error("row end did not clear column and mask");

  a_image_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_o && pix_o.image_last |=> image_done_q)
    else $error("final pixel did not close the image");

  a_data_leaves_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live && in_i.ready |-> pix_valid_o && pix_o.run_last)
    else $error("data beat released before its last pixel");
`endif

endmodule

`default_nettype wire

/* sv/ibpu_out_reg.sv */
// Output register: holds one decoded pixel and picks palette or direct color.
// Depends on ibpu_pkg, ibpu_if.
`default_nettype none

module ibpu_out_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pix_valid_i,
  input  ibpu_pkg::pix_t                pix_i,
  output logic                          pix_ready_o,
  input  logic [ibpu_pkg::COLOR_W-1:0]  pal_rdata_i,
  ibpu_out_if.source                    out_o
);
  import ibpu_pkg::*;

  logic valid_q;
  pix_t pix_q;

  assign pix_ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_ready_o && pix_valid_i) begin
      pix_q <= pix_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.pixel_color   = pix_q.use_pal ? pal_rdata_i : pix_q.color;
  assign out_o.column        = pix_q.column;
  assign out_o.row           = pix_q.row;
  assign out_o.run_last      = pix_q.run_last;
  assign out_o.image_last    = pix_q.image_last;
  assign out_o.mask_underrun = pix_q.mask_underrun;

endmodule

`default_nettype wire

/* sv/icon_bitmap_pixel_unpacker_unit.sv */
// Icon bitmap pixel unpacker, top level.
// A data beat passes the held-item register; each of its pixels then passes the output register.
// One pixel per cycle through the output register and palette read port unless output stalls;
// a data beat yields 8/4/2/1 pixels at 1/2/4/8 bpp and one at 24 bpp, fewer at a row end.
// Palette writes, mask beats and dropped data beats leave without waiting on the output.
// Reset: counters, mask and done flag clear, 8 bpp 32x32; palette is undefined until written.
`default_nettype none

module icon_bitmap_pixel_unpacker_unit #(
  parameter int MAX_DIMENSION = ibpu_pkg::MAX_DIMENSION_DEF,
  parameter int PALETTE_DEPTH = ibpu_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ibpu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ibpu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ibpu_in_if.sink                          in_i,
  ibpu_out_if.source                       out_o
);
  import ibpu_pkg::*;

  localparam int PalAw = $clog2(PALETTE_DEPTH);

  cfg_t               cfg;
  pix_t               pix;
  logic               pix_valid, pix_ready;
  logic               pal_we, pal_re;
  logic [PalAw-1:0]   pal_waddr, pal_raddr;
  logic [COLOR_W-1:0] pal_wdata, pal_rdata;

  ibpu_cfg #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ibpu_unpack #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .pix_ready_i (pix_ready),
    .pix_valid_o (pix_valid),
    .pix_o       (pix),
    .pal_we_o    (pal_we),
    .pal_waddr_o (pal_waddr),
    .pal_wdata_o (pal_wdata),
    .pal_re_o    (pal_re),
    .pal_raddr_o (pal_raddr)
  );

  ibpu_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  ibpu_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_valid),
    .pix_i       (pix),
    .pix_ready_o (pix_ready),
    .pal_rdata_i (pal_rdata),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
